// File: src/wrs_pkg.sv
// shared types and constants of the warp register scoreboard
`default_nettype none
package wrs_pkg;

	localparam int WARP_SLOTS_DEF = 16;
	localparam int SLOT_W         = 4;
	localparam int REG_COUNT      = 256;
	localparam int PRED_COUNT     = 8;
	localparam int REG_IDX_W      = 8;
	localparam int PRED_IDX_W     = 3;
	localparam int DST_REG_N      = 4;
	localparam int SRC_REG_N      = 4;
	localparam int SRC_PRED_N     = 4;
	localparam int DST_PRED_N     = 2;
	localparam int IN_TDATA_W     = 88;
	localparam int OUT_TDATA_W    = 8;

	typedef enum logic [1:0] {
		FUNC_RESERVE = 2'd0,
		FUNC_RELEASE = 2'd1,
		FUNC_CHECK   = 2'd2
	} func_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic wr;
		logic collision;
		logic reserve_error;
	} exec_res_t;

endpackage
`default_nettype wire

// File: src/warp_register_scoreboard_top.sv
// Warp register scoreboard: per-warp busy maps of registers and predicates.
// One input stream (s_axis) carries instructions: reserve, release or check
// against the busy maps of the named warp slot. One output stream (m_axis)
// returns exactly one result item per input item: collision for a check,
// reserve_error for a reserve, zeros otherwise.
// Each item passes through the states IDLE and EXEC: the row of the warp
// slot is read from the busy memory at the accepting edge in IDLE, and
// EXEC computes the result, writes the row back and loads the output
// register. The result is valid from the edge that ends EXEC. No new item
// is accepted during EXEC, so the read-then-write of the row bounds the
// item rate.
// Warp slots at or above WARP_SLOTS are not stored: no change, zero result.
// Reset clears a valid bit per row, so every map reads as all zero right
// away; no clearing pass is needed.
// When the receiver stalls, the result waits in the output register and
// the next item is accepted in the same cycle that the result is taken.
`default_nettype none
module warp_register_scoreboard_top #(
	parameter int WARP_SLOTS = wrs_pkg::WARP_SLOTS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// func, warp_slot, dst_regs, src_regs, src_preds, dst_preds
	input  wire logic [wrs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// collision, reserve_error, zero fill
	output logic [wrs_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
	import wrs_pkg::*;

	localparam int AW    = (WARP_SLOTS > 1) ? $clog2(WARP_SLOTS) : 1;
	localparam int CMP_W = 7;

	localparam int DR_W = DST_REG_N * REG_IDX_W;
	localparam int SR_W = SRC_REG_N * REG_IDX_W;
	localparam int SP_W = SRC_PRED_N * PRED_IDX_W;
	localparam int DP_W = DST_PRED_N * PRED_IDX_W;

	localparam int FUNC_LO = 0;
	localparam int SLOT_LO = FUNC_LO + 2;
	localparam int DR_LO   = SLOT_LO + SLOT_W;
	localparam int SR_LO   = DR_LO + DR_W;
	localparam int SP_LO   = SR_LO + SR_W;
	localparam int DP_LO   = SP_LO + SP_W;

	state_t state_q, state_nxt;

	logic accept;
	logic exec_en;

	logic [SLOT_W-1:0] in_slot;
	logic [CMP_W-1:0]  in_slot_ext;
	logic [AW-1:0]     in_addr;
	logic              in_range;

	func_t            func_s1;
	logic [AW-1:0]    addr_s1;
	logic             in_range_s1;
	logic             row_valid_s1;
	logic [DR_W-1:0]  dst_regs_s1;
	logic [SR_W-1:0]  src_regs_s1;
	logic [SP_W-1:0]  src_preds_s1;
	logic [DP_W-1:0]  dst_preds_s1;

	logic [REG_COUNT-1:0]  reg_mem  [WARP_SLOTS];
	logic [PRED_COUNT-1:0] pred_mem [WARP_SLOTS];
	logic [REG_COUNT-1:0]  reg_rd_s1;
	logic [PRED_COUNT-1:0] pred_rd_s1;
	logic [WARP_SLOTS-1:0] row_valid_q;

	logic [REG_COUNT-1:0]  reg_map;
	logic [PRED_COUNT-1:0] pred_map;
	logic [REG_COUNT-1:0]  reg_map_nxt;
	logic [PRED_COUNT-1:0] pred_map_nxt;
	exec_res_t             res;
	logic                  wr_en;

	logic m_valid_q;
	logic collision_q;
	logic reserve_error_q;

	assign in_slot     = s_axis_tdata[SLOT_LO +: SLOT_W];
	assign in_slot_ext = CMP_W'(in_slot);
	assign in_addr     = in_slot_ext[AW-1:0];
	assign in_range    = in_slot_ext < CMP_W'(WARP_SLOTS);
	assign accept      = s_axis_tvalid & s_axis_tready;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_nxt = ST_EXEC;
			ST_EXEC: state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_axis_tready = 1'b0;
		exec_en       = 1'b0;
		unique case (state_q)
			ST_IDLE: s_axis_tready = ~m_valid_q | m_axis_tready;
			ST_EXEC: exec_en = 1'b1;
			default: s_axis_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nxt;
	end

	// item capture and row read
	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1      <= func_t'(s_axis_tdata[FUNC_LO +: 2]);
			addr_s1      <= in_addr;
			in_range_s1  <= in_range;
			row_valid_s1 <= in_range ? row_valid_q[in_addr] : 1'b0;
			dst_regs_s1  <= s_axis_tdata[DR_LO +: DR_W];
			src_regs_s1  <= s_axis_tdata[SR_LO +: SR_W];
			src_preds_s1 <= s_axis_tdata[SP_LO +: SP_W];
			dst_preds_s1 <= s_axis_tdata[DP_LO +: DP_W];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			reg_rd_s1  <= reg_mem[in_addr];
			pred_rd_s1 <= pred_mem[in_addr];
		end
		if (wr_en) begin
			reg_mem[addr_s1]  <= reg_map_nxt;
			pred_mem[addr_s1] <= pred_map_nxt;
		end
	end

	// a row never written since reset reads as all free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			row_valid_q <= '0;
		else if (wr_en)
			row_valid_q[addr_s1] <= 1'b1;
	end

	assign reg_map  = row_valid_s1 ? reg_rd_s1 : '0;
	assign pred_map = row_valid_s1 ? pred_rd_s1 : '0;

	wrs_exec u_exec (
		.func         (func_s1),
		.dst_regs     (dst_regs_s1),
		.src_regs     (src_regs_s1),
		.src_preds    (src_preds_s1),
		.dst_preds    (dst_preds_s1),
		.reg_map      (reg_map),
		.pred_map     (pred_map),
		.reg_map_nxt  (reg_map_nxt),
		.pred_map_nxt (pred_map_nxt),
		.res          (res)
	);

	assign wr_en = exec_en & in_range_s1 & res.wr;

	// output register, empty whenever the exec cycle comes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (exec_en)
			m_valid_q <= 1'b1;
		else if (m_axis_tready)
			m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (exec_en) begin
			collision_q     <= in_range_s1 & res.collision;
			reserve_error_q <= in_range_s1 & res.reserve_error;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W-2){1'b0}}, reserve_error_q, collision_q};

endmodule
`default_nettype wire

// File: src/wrs_exec.sv
// update and lookup logic for one warp row of busy maps
`default_nettype none
module wrs_exec (
	input  wire wrs_pkg::func_t                                           func,
	input  wire logic [wrs_pkg::DST_REG_N*wrs_pkg::REG_IDX_W-1:0]        dst_regs,
	input  wire logic [wrs_pkg::SRC_REG_N*wrs_pkg::REG_IDX_W-1:0]        src_regs,
	input  wire logic [wrs_pkg::SRC_PRED_N*wrs_pkg::PRED_IDX_W-1:0]      src_preds,
	input  wire logic [wrs_pkg::DST_PRED_N*wrs_pkg::PRED_IDX_W-1:0]      dst_preds,
	input  wire logic [wrs_pkg::REG_COUNT-1:0]                           reg_map,
	input  wire logic [wrs_pkg::PRED_COUNT-1:0]                          pred_map,
	output logic [wrs_pkg::REG_COUNT-1:0]                                reg_map_nxt,
	output logic [wrs_pkg::PRED_COUNT-1:0]                               pred_map_nxt,
	output wrs_pkg::exec_res_t                                           res
);
	import wrs_pkg::*;

	logic [REG_COUNT-1:0]  reg_set;
	logic [PRED_COUNT-1:0] pred_set;
	logic                  dst_busy;
	logic                  dst_dup;
	logic                  any_busy;

	always_comb begin
		logic [REG_IDX_W-1:0]  r;
		logic [REG_IDX_W-1:0]  rj;
		logic [PRED_IDX_W-1:0] p;
		reg_set  = '0;
		pred_set = '0;
		dst_busy = 1'b0;
		dst_dup  = 1'b0;
		any_busy = 1'b0;
		for (int i = 0; i < DST_REG_N; i++) begin
			r = dst_regs[REG_IDX_W*i +: REG_IDX_W];
			if (r != '0) begin
				reg_set[r] = 1'b1;
				if (reg_map[r])
					dst_busy = 1'b1;
			end
			for (int j = 0; j < i; j++) begin
				rj = dst_regs[REG_IDX_W*j +: REG_IDX_W];
				if (r != '0 && r == rj)
					dst_dup = 1'b1;
			end
		end
		for (int i = 0; i < SRC_REG_N; i++) begin
			r = src_regs[REG_IDX_W*i +: REG_IDX_W];
			if (r != '0 && reg_map[r])
				any_busy = 1'b1;
		end
		for (int i = 0; i < DST_PRED_N; i++) begin
			p = dst_preds[PRED_IDX_W*i +: PRED_IDX_W];
			if (p != '0) begin
				pred_set[p] = 1'b1;
				if (pred_map[p])
					dst_busy = 1'b1;
			end
		end
		// two predicate destinations only: one pair to compare
		if (dst_preds[PRED_IDX_W-1:0] != '0 &&
		    dst_preds[PRED_IDX_W-1:0] == dst_preds[2*PRED_IDX_W-1:PRED_IDX_W])
			dst_dup = 1'b1;
		for (int i = 0; i < SRC_PRED_N; i++) begin
			p = src_preds[PRED_IDX_W*i +: PRED_IDX_W];
			if (p != '0 && pred_map[p])
				any_busy = 1'b1;
		end
	end

	always_comb begin
		reg_map_nxt  = reg_map;
		pred_map_nxt = pred_map;
		res          = '0;
		unique case (func)
			FUNC_RESERVE: begin
				reg_map_nxt       = reg_map | reg_set;
				pred_map_nxt      = pred_map | pred_set;
				res.wr            = 1'b1;
				res.reserve_error = dst_busy | dst_dup;
			end
			FUNC_RELEASE: begin
				reg_map_nxt  = reg_map & ~reg_set;
				pred_map_nxt = pred_map & ~pred_set;
				res.wr       = 1'b1;
			end
			FUNC_CHECK: begin
				res.collision = dst_busy | any_busy;
			end
			default: begin
				res = '0;
			end
		endcase
	end

endmodule
`default_nettype wire
